// File: rtl/min_spacing_message_regulator_top_assert.svh
// assertion macros shared by the regulator checker
`ifndef MIN_SPACING_MESSAGE_REGULATOR_TOP_ASSERT_SVH
`define MIN_SPACING_MESSAGE_REGULATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MSMR_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("regulator check failed");

// next-cycle implication, disabled during reset
`define MSMR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("regulator check failed");

`endif

// File: rtl/msmr_pkg.sv
// shared types and constants of the minimum-spacing message regulator
package msmr_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ID_W            = 11;
    localparam int TICK_W          = 32;
    localparam int SPACING_W       = 16;

    // input kind on tuser
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_ARRIVAL = 1'b1;

    // result kind on tuser
    localparam logic RES_DELIVER = 1'b0;
    localparam logic RES_DROP    = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] due_tick;
        logic [ID_W-1:0]   id;
    } queue_entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// File: rtl/min_spacing_message_regulator_top.sv
// top level of the minimum-spacing message regulator
//
// input stream: s_tuser is the item kind (tick or message arrival), s_tdata
// carries the message id; each transfer advances time by one tick or queues
// a message for delivery at max(now, last delivery + min_spacing)
// output stream: m_tuser is the result kind (delivered or dropped), m_tdata
// carries the message id and the tick count at which the result occurred
// config channel: cfg_data sets min_spacing, always ready, write only while idle
//
// the queue is a row of cells with the head in cell 0; a pop shifts every
// cell one place toward the head, a push loads the first free cell
// one input transfer per cycle unless a held result is stalled; a result, if any, is
// registered and shows on the output in the cycle after its input transfer;
// the rate rests on a combinational schedule add, due compare and cell shift
// when the receiver stalls the result is held and s_tready drops until it
// is taken; a new input is accepted in the same cycle the result is taken
// reset clears time, schedule, spacing, fill count and output valid; cell
// contents are left as they are, since an empty cell is never read
module min_spacing_message_regulator_top
#(
    parameter int QUEUE_DEPTH = msmr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] msg_id, [15:11] zero
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [10:0] out_id, [42:11] out_time, [47:43] zero
    output logic        m_tuser,   // [0] result_kind
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // [15:0] min_spacing
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W   = msmr_pkg::ID_W;
    localparam int TICK_W = msmr_pkg::TICK_W;
    localparam int SP_W   = msmr_pkg::SPACING_W;

    // control and time state
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic [TICK_W-1:0] now_reg,     now_next;
    logic [TICK_W-1:0] last_reg,    last_next;
    logic [SP_W-1:0]   spacing_reg, spacing_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg,  out_kind_next;
    logic [ID_W-1:0]   out_id_reg,    out_id_next;
    logic [TICK_W-1:0] out_time_reg,  out_time_next;

    // cell row
    msmr_pkg::queue_entry_t cell_q [QUEUE_DEPTH];
    msmr_pkg::cell_ctrl_t   cell_ctrl [QUEUE_DEPTH];
    msmr_pkg::queue_entry_t new_entry;

    logic              accept;
    logic              is_arrival;
    logic              full;
    logic              empty;
    logic              push;
    logic              drop;
    logic              pop;
    logic              due;
    logic              bypass;
    logic [ID_W-1:0]   in_id;
    logic [TICK_W-1:0] now_step;
    logic [TICK_W-1:0] sched_sum;
    logic [TICK_W-1:0] sched_diff;
    logic [TICK_W-1:0] sched_t;
    logic              sched_late;
    logic [TICK_W-1:0] head_diff;
    logic [FILL_W-1:0] wr_idx;

    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign is_arrival = (s_tuser == msmr_pkg::ACT_ARRIVAL);
    assign in_id      = s_tdata[ID_W-1:0];
    assign full       = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty      = (fill_reg == '0);

    // time after this item: a tick advances it first
    assign now_step = is_arrival ? now_reg : now_reg + TICK_W'(1);

    // delivery time of an arrival: max(now, last + spacing) in wrapped time
    assign sched_sum  = last_reg + TICK_W'(spacing_reg);
    assign sched_diff = sched_sum - now_reg;
    assign sched_late = !sched_diff[TICK_W-1];
    assign sched_t    = sched_late ? sched_sum : now_reg;

    assign push = accept && is_arrival && !full;
    assign drop = accept && is_arrival && full;

    // head due check: on an empty queue the new entry is due when its time is now
    assign head_diff = now_step - cell_q[0].due_tick;
    always_comb
    begin
        if (empty)
        begin
            due = push && (!sched_late || (sched_sum == now_reg));
        end
        else
        begin
            due = !head_diff[TICK_W-1];
        end
    end

    assign pop    = accept && !drop && due;
    // an arrival into an empty queue that is due at once skips the cells
    assign bypass = empty && pop;

    assign new_entry.id       = in_id;
    assign new_entry.due_tick = sched_t;

    // first free cell, one place lower when the row shifts in the same cycle
    assign wr_idx = pop ? fill_reg - FILL_W'(1) : fill_reg;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        msmr_pkg::queue_entry_t nb;

        assign cell_ctrl[i].shift = pop;
        assign cell_ctrl[i].load  = push && !bypass && (wr_idx == FILL_W'(i));

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign nb = cell_q[i];
        end
        else
        begin : g_body
            assign nb = cell_q[i+1];
        end

        msmr_cell u_cell
        (
            .clk       (clk),
            .ctrl      (cell_ctrl[i]),
            .new_entry (new_entry),
            .neighbor  (nb),
            .entry     (cell_q[i])
        );
    end

    always_comb
    begin
        fill_next      = fill_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        spacing_next   = spacing_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_time_next  = out_time_reg;

        if (cfg_valid && cfg_ready)
        begin
            spacing_next = cfg_data;
        end

        if (accept)
        begin
            now_next = now_step;
        end

        if (push)
        begin
            last_next = sched_t;
        end

        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + FILL_W'(1);
            2'b01:   fill_next = fill_reg - FILL_W'(1);
            default: fill_next = fill_reg;
        endcase

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (drop || pop)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = drop ? msmr_pkg::RES_DROP : msmr_pkg::RES_DELIVER;
            out_id_next    = (drop || empty) ? in_id : cell_q[0].id;
            out_time_next  = now_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            now_reg       <= '0;
            last_reg      <= '0;
            spacing_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            now_reg       <= now_next;
            last_reg      <= last_next;
            spacing_reg   <= spacing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_time_reg <= out_time_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_time_reg, out_id_reg};

endmodule

// File: rtl/msmr_cell.sv
// one queue cell: holds an entry, loads a new one or takes its neighbor's on a pop
module msmr_cell
(
    input  logic                  clk,
    input  msmr_pkg::cell_ctrl_t  ctrl,
    input  msmr_pkg::queue_entry_t new_entry,
    input  msmr_pkg::queue_entry_t neighbor,
    output msmr_pkg::queue_entry_t entry
);

    msmr_pkg::queue_entry_t entry_reg;
    msmr_pkg::queue_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.load)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/msmr_checker.sv
// port-level checks of the regulator, bound to its top level
`include "min_spacing_message_regulator_top_assert.svh"

module msmr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a stalled result holds its payload
    `MSMR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // input is open whenever no result is pending
    `MSMR_ASSERT_NOW(a_in_open, clk, rst_n, !m_tvalid, s_tready)

    // a new result only follows an input transfer
    `MSMR_ASSERT_NEXT(a_out_cause, clk, rst_n, !m_tvalid,
        !m_tvalid || $past(s_tvalid && s_tready))

    // a tick never causes a drop
    `MSMR_ASSERT_NEXT(a_tick_no_drop, clk, rst_n, s_tvalid && s_tready && !s_tuser,
        !(m_tvalid && m_tuser))

    // configuration is always taken
    `MSMR_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind min_spacing_message_regulator_top msmr_checker u_msmr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: verif/min_spacing_message_regulator_checker.sv
// checker for the regulator: predicts results from observed transfers and compares them
module min_spacing_message_regulator_checker
#(
    parameter int QUEUE_DEPTH = msmr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] msg_id, [15:11] zero
    input  logic        s_tuser,   // [0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [10:0] out_id, [42:11] out_time, [47:43] zero
    input  logic        m_tuser,   // [0] result_kind
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,  // [15:0] min_spacing
    output int          mismatch_count,
    output int          pending_results
);

    localparam int ID_W      = msmr_pkg::ID_W;
    localparam int TICK_W    = msmr_pkg::TICK_W;
    localparam int SPACING_W = msmr_pkg::SPACING_W;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] at_tick;
    } outcome_t;

    // results still owed by the block, oldest first
    outcome_t             owed_results[$];

    // shadow of the regulator state
    logic [SPACING_W-1:0] spacing;
    logic [TICK_W-1:0]    now_tick;
    logic [TICK_W-1:0]    last_due;
    logic [ID_W-1:0]      held_id  [QUEUE_DEPTH];
    logic [TICK_W-1:0]    held_due [QUEUE_DEPTH];
    int                   head;
    int                   tail;
    int                   fill;

    // a is at or past b on the wrapping tick scale
    function automatic logic reached(input logic [TICK_W-1:0] a,
                                     input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return !diff[TICK_W-1];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t          want;
        outcome_t          made;
        logic              dropped;
        logic [TICK_W-1:0] due;
        if (!rst_n)
        begin
            spacing         = '0;
            now_tick        = '0;
            last_due        = '0;
            head            = 0;
            tail            = 0;
            fill            = 0;
            mismatch_count  = 0;
            pending_results = 0;
            owed_results.delete();
        end
        else
        begin
            // result side first: a result never stems from an input of the same edge
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: kind %0d id %0d tick %0d",
                                 m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W +: TICK_W]);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata[ID_W-1:0] !== want.id ||
                        m_tdata[ID_W +: TICK_W] !== want.at_tick)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected kind %0d id %0d tick %0d,",
                                     want.kind, want.id, want.at_tick,
                                     " got kind %0d id %0d tick %0d",
                                     m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W +: TICK_W]);
                    end
                end
            end

            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                spacing = cfg_data[SPACING_W-1:0];

            if (s_tvalid === 1'b1 && s_tready === 1'b1)
            begin
                dropped = 1'b0;
                if (s_tuser == msmr_pkg::ACT_TICK)
                    now_tick = now_tick + TICK_W'(1);
                else if (fill >= QUEUE_DEPTH)
                begin
                    // queue full: report the drop, nothing is released this step
                    dropped      = 1'b1;
                    made.kind    = msmr_pkg::RES_DROP;
                    made.id      = s_tdata[ID_W-1:0];
                    made.at_tick = now_tick;
                    owed_results.push_back(made);
                end
                else
                begin
                    due = last_due + TICK_W'(spacing);
                    if (!reached(due, now_tick))
                        due = now_tick;
                    last_due       = due;
                    held_id[tail]  = s_tdata[ID_W-1:0];
                    held_due[tail] = due;
                    tail           = (tail + 1) % QUEUE_DEPTH;
                    fill++;
                end

                // at most one delivery per step, oldest entry first
                if (!dropped && fill > 0 && reached(now_tick, held_due[head]))
                begin
                    made.kind    = msmr_pkg::RES_DELIVER;
                    made.id      = held_id[head];
                    made.at_tick = now_tick;
                    owed_results.push_back(made);
                    head = (head + 1) % QUEUE_DEPTH;
                    fill--;
                end
            end

            pending_results = owed_results.size();
        end
    end

endmodule

// File: verif/min_spacing_message_regulator_top_test.sv
// testbench top of the minimum-spacing message regulator: stimulus and verdict
module min_spacing_message_regulator_top_test;

    localparam int ID_W      = msmr_pkg::ID_W;
    localparam int SPACING_W = msmr_pkg::SPACING_W;

    // clock, reset and block inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;    // [10:0] msg_id, [15:11] zero
    logic        s_tuser   = 1'b0;  // [0] action
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;    // [15:0] min_spacing

    // block outputs
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;           // [10:0] out_id, [42:11] out_time, [47:43] zero
    logic        m_tuser;           // [0] result_kind
    logic        cfg_ready;

    // from the checker
    int          mismatch_count;
    int          pending_results;

    // idling control for the sender and the receiver
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    int          stall_left     = 0;

    min_spacing_message_regulator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    min_spacing_message_regulator_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // period of 2 time units
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stall bursts, changed on the falling edge
    always @(negedge clk)
    begin
        if (!receiver_idles)
            m_tready = 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            m_tready   = 1'b0;
        end
        else
            m_tready = 1'b1;
    end

    // one input transfer; entered and left on a falling edge
    // valid stays high between back-to-back transfers, an idle burst lowers it first
    task automatic send_item(input logic act, input logic [ID_W-1:0] id);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {5'b0, id};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        @(negedge clk);
    endtask

    // register write while idle: input quiet, no result owed, and any result
    // still in flight let through to the output first
    task automatic write_spacing(input logic [SPACING_W-1:0] value);
        s_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random traffic at one spacing: arrivals about once per spacing window,
    // plus arrival bursts that back the queue up and cause drops; then
    // enough ticks to empty the queue before the next setting
    task automatic run_phase(input int spacing_val, input int count);
        int done;
        int burst;
        write_spacing(spacing_val[SPACING_W-1:0]);
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                burst = $urandom_range(3, 10);
                repeat (burst)
                    send_item(msmr_pkg::ACT_ARRIVAL, ID_W'($urandom_range(0, 2047)));
                done += burst;
            end
            else
            begin
                send_item(($urandom_range(0, spacing_val + 1) == 0) ?
                              msmr_pkg::ACT_ARRIVAL : msmr_pkg::ACT_TICK,
                          ID_W'($urandom_range(0, 2047)));
                done++;
            end
        end
        repeat (spacing_val * 9 + 2)
            send_item(msmr_pkg::ACT_TICK, ID_W'($urandom_range(0, 2047)));
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // spacing at reset value zero: both id extremes are delivered at tick 0
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h000);
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h7FF);
        send_item(msmr_pkg::ACT_TICK, 11'h7FF);

        // spacing 1: first arrival goes out at once, eight queue up, the tenth is dropped
        write_spacing(16'd1);
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h555);
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h2AA);
        repeat (7) send_item(msmr_pkg::ACT_ARRIVAL, ID_W'($urandom_range(0, 2047)));
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h7FF);

        // release half, then spacing 0 queues three entries due on the same
        // tick as the last one, so several come due at once
        write_spacing(16'd0);
        repeat (4) send_item(msmr_pkg::ACT_TICK, 11'h000);
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h001);
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h400);
        send_item(msmr_pkg::ACT_ARRIVAL, 11'h3FF);
        repeat (7) send_item(msmr_pkg::ACT_TICK, ID_W'($urandom_range(0, 2047)));

        // random part over several spacings, one stretch with no idling
        run_phase(0, 90);
        run_phase(1, 90);
        run_phase(2, 90);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_phase(5, 90);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        run_phase($urandom_range(0, 15), 90);
        run_phase($urandom_range(0, 15), 90);
        run_phase(25, 90);

        // last part: no idling on either side
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_phase(0, 90);

        // largest spacing last, since it pushes every later delivery far out:
        // the queue fills and further arrivals are dropped
        write_spacing(16'hFFFF);
        repeat (60)
            send_item(($urandom_range(0, 3) != 0) ?
                          msmr_pkg::ACT_ARRIVAL : msmr_pkg::ACT_TICK,
                      ID_W'($urandom_range(0, 2047)));

        s_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, far above the slowest correct run
    initial
    begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
